@@ src/esm_pkg.sv @@
// Shared types and constants for the effect slot manager.
// No dependencies; the other files refer to it as esm_pkg::name.
package esm_pkg;

  // Default pool size and fixed field widths
  localparam int SLOT_COUNT_DEF = 16;
  localparam int MARK_W         = 6;   // params, envelope, condition, periodic, constant, ramp
  localparam int MASK_W         = 16;  // slots reported in the masks
  localparam int LOAD_W         = 5;

  // Item codes carried in in_tuser
  typedef enum logic [3:0] {
    MODE_CREATE       = 4'd0,
    MODE_FREE         = 4'd1,
    MODE_START        = 4'd2,
    MODE_START_SOLO   = 4'd3,
    MODE_STOP         = 4'd4,
    MODE_STOP_ALL     = 4'd5,
    MODE_DEV_RESET    = 4'd6,
    MODE_ENABLE       = 4'd7,
    MODE_DISABLE      = 4'd8,
    MODE_SET_PARAMS   = 4'd9,
    MODE_SET_ENVELOPE = 4'd10,
    MODE_SET_COND     = 4'd11,
    MODE_SET_PERIODIC = 4'd12,
    MODE_SET_CONSTANT = 4'd13,
    MODE_SET_RAMP     = 4'd14,
    MODE_NONE         = 4'd15
  } mode_t;

  // Command to the slot update unit
  typedef struct packed {
    mode_t mode;
    logic  hit;     // slot under the sequencer is the addressed slot
  } slot_cmd_t;

  // Update returned by the slot update unit
  typedef struct packed {
    logic              alloc;
    logic              started;
    logic              clr_marks;
    logic [MARK_W-1:0] set_marks;
    logic              found;     // create has taken this slot
  } slot_upd_t;

endpackage

@@ src/esm_slot_unit.sv @@
// Shared slot update unit: next flags of the one slot the sequencer points at.
// Depends on esm_pkg.
module esm_slot_unit (
  input  esm_pkg::slot_cmd_t cmd,
  input  logic               alloc_i,
  input  logic               started_i,
  output esm_pkg::slot_upd_t upd
);

  logic [3:0] mark_sel;

  assign mark_sel = cmd.mode - esm_pkg::MODE_SET_PARAMS;

  always_comb begin
    upd           = '0;
    upd.alloc     = alloc_i;
    upd.started   = started_i;
    case (cmd.mode)
      esm_pkg::MODE_CREATE: begin
        // first free slot: fresh allocation
        if (!alloc_i) begin
          upd.alloc     = 1'b1;
          upd.started   = 1'b0;
          upd.clr_marks = 1'b1;
          upd.found     = 1'b1;
        end
      end
      esm_pkg::MODE_FREE: begin
        if (cmd.hit) upd.alloc = 1'b0;
      end
      esm_pkg::MODE_START: begin
        if (cmd.hit) upd.started = 1'b1;
      end
      esm_pkg::MODE_STOP: begin
        if (cmd.hit) upd.started = 1'b0;
      end
      esm_pkg::MODE_START_SOLO: begin
        upd.started = cmd.hit;
      end
      esm_pkg::MODE_STOP_ALL: begin
        upd.started = 1'b0;
      end
      esm_pkg::MODE_DEV_RESET: begin
        upd.alloc     = 1'b0;
        upd.started   = 1'b0;
        upd.clr_marks = 1'b1;
      end
      esm_pkg::MODE_SET_PARAMS, esm_pkg::MODE_SET_ENVELOPE, esm_pkg::MODE_SET_COND,
      esm_pkg::MODE_SET_PERIODIC, esm_pkg::MODE_SET_CONSTANT, esm_pkg::MODE_SET_RAMP: begin
        if (cmd.hit) upd.set_marks = esm_pkg::MARK_W'(1) << mark_sel;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ src/effect_slot_manager.sv @@
// Effect slot manager top level: sequencer, slot flag storage and result register.
// Depends on esm_pkg and esm_slot_unit.
//
// Usage:
//   Input transactions carry one host command: in_tuser holds the command code,
//   in_tdata the one-based slot index and the parameter block offset. Every command
//   gives exactly one result transaction reporting the state after the command: the
//   last create's index and status, the allocated and started masks of slots 0..15,
//   and the actuator enable.
//   Enable, disable, no-op and ignored commands go straight to the result, commands on
//   one slot visit only that slot. Create scans one slot per cycle from slot 0 and
//   stops at the first free one or, when the pool is full, at the last slot; start
//   solo, stop all and device reset walk the whole pool.
//   Throughput is one command at a time, bounded by the single slot update unit: the
//   next command is taken the cycle after the result is registered.
//   in_tready is high only while the sequencer is idle.
//   A finished result sits in the output register; the next command is accepted while
//   it waits, and only the following result is held back until out_tready.
//   Reset (rst_n low, synchronous) clears every slot, the create record and the
//   actuator enable, and empties the output register.
module effect_slot_manager #(
  parameter int SLOT_COUNT = esm_pkg::SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] block_index, [15:8] axis_offset
  input  logic [3:0]  in_tuser,   // [3:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [4:0] load_index, [5] load_full, [21:6] allocated_mask,
                                  // [37:22] started_mask, [38] actuators_on, [39] zero
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                      state_r, state_nxt;
  esm_pkg::mode_t              mode_r, mode_nxt;
  logic [IDX_W-1:0]            cnt_r, cnt_nxt;
  logic [IDX_W-1:0]            tgt_r, tgt_nxt;
  logic                        single_r, single_nxt;
  logic                        act_r, act_nxt;
  logic [esm_pkg::LOAD_W-1:0]  load_idx_r, load_idx_nxt;
  logic                        load_full_r, load_full_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [39:0]                 out_data_r, out_data_nxt;

  logic [SLOT_COUNT-1:0]       alloc_r;
  logic [SLOT_COUNT-1:0]       started_r;
  logic [esm_pkg::MARK_W-1:0]  marks_r [SLOT_COUNT];

  esm_pkg::mode_t              in_mode;
  logic [7:0]                  in_blk;
  logic [7:0]                  in_axis;
  logic [7:0]                  blk_m1;
  logic                        blk_ok;
  logic                        in_acc;
  logic                        scan_en;
  logic                        last_slot;
  logic [7:0]                  cnt_p1;
  logic                        out_load;
  logic [esm_pkg::MASK_W-1:0]  amask, smask;

  esm_pkg::slot_cmd_t          cmd;
  esm_pkg::slot_upd_t          upd;

  // Input decode
  assign in_mode   = esm_pkg::mode_t'(in_tuser);
  assign in_blk    = in_tdata[7:0];
  assign in_axis   = in_tdata[15:8];
  assign blk_m1    = in_blk - 8'd1;
  assign blk_ok    = (in_blk != 8'd0) && (in_blk <= 8'(SLOT_COUNT));
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign scan_en   = (state_r == S_SCAN);
  assign last_slot = (cnt_r == LAST_IDX);
  assign cnt_p1    = 8'(cnt_r) + 8'd1;

  // Shared slot update unit
  assign cmd.mode = mode_r;
  assign cmd.hit  = (cnt_r == tgt_r);

  esm_slot_unit u_slot (
    .cmd       (cmd),
    .alloc_i   (alloc_r[cnt_r]),
    .started_i (started_r[cnt_r]),
    .upd       (upd)
  );

  // Masks of the first sixteen slots
  for (genvar g = 0; g < esm_pkg::MASK_W; g++) begin : g_mask
    if (g < SLOT_COUNT) begin : g_on
      assign amask[g] = alloc_r[g];
      assign smask[g] = started_r[g];
    end else begin : g_off
      assign amask[g] = 1'b0;
      assign smask[g] = 1'b0;
    end
  end

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    tgt_nxt       = tgt_r;
    single_nxt    = single_r;
    act_nxt       = act_r;
    load_idx_nxt  = load_idx_r;
    load_full_nxt = load_full_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt   = in_mode;
          tgt_nxt    = blk_m1[IDX_W-1:0];
          cnt_nxt    = '0;
          single_nxt = 1'b0;
          state_nxt  = S_DONE;
          case (in_mode)
            esm_pkg::MODE_CREATE, esm_pkg::MODE_STOP_ALL: begin
              state_nxt = S_SCAN;
            end
            esm_pkg::MODE_DEV_RESET: begin
              act_nxt   = 1'b1;
              state_nxt = S_SCAN;
            end
            esm_pkg::MODE_START_SOLO: begin
              if (blk_ok) state_nxt = S_SCAN;
            end
            esm_pkg::MODE_FREE, esm_pkg::MODE_START, esm_pkg::MODE_STOP,
            esm_pkg::MODE_SET_PARAMS, esm_pkg::MODE_SET_ENVELOPE,
            esm_pkg::MODE_SET_PERIODIC, esm_pkg::MODE_SET_CONSTANT,
            esm_pkg::MODE_SET_RAMP: begin
              if (blk_ok) begin
                cnt_nxt    = blk_m1[IDX_W-1:0];
                single_nxt = 1'b1;
                state_nxt  = S_SCAN;
              end
            end
            esm_pkg::MODE_SET_COND: begin
              // condition block only counts at axis offset zero
              if (blk_ok && (in_axis == 8'd0)) begin
                cnt_nxt    = blk_m1[IDX_W-1:0];
                single_nxt = 1'b1;
                state_nxt  = S_SCAN;
              end
            end
            esm_pkg::MODE_ENABLE:  act_nxt = 1'b1;
            esm_pkg::MODE_DISABLE: act_nxt = 1'b0;
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (mode_r == esm_pkg::MODE_CREATE && upd.found) begin
          load_idx_nxt  = cnt_p1[esm_pkg::LOAD_W-1:0];
          load_full_nxt = 1'b0;
          state_nxt     = S_DONE;
        end else if (single_r) begin
          state_nxt = S_DONE;
        end else if (last_slot) begin
          if (mode_r == esm_pkg::MODE_CREATE) begin
            // pool full
            load_idx_nxt  = '0;
            load_full_nxt = 1'b1;
          end
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {1'b0, act_r, smask, amask, load_full_r, load_idx_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= esm_pkg::MODE_NONE;
      cnt_r       <= '0;
      tgt_r       <= '0;
      single_r    <= 1'b0;
      act_r       <= 1'b0;
      load_idx_r  <= '0;
      load_full_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      tgt_r       <= tgt_nxt;
      single_r    <= single_nxt;
      act_r       <= act_nxt;
      load_idx_r  <= load_idx_nxt;
      load_full_r <= load_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Slot flags: one slot written per scan cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r   <= '0;
      started_r <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) marks_r[i] <= '0;
    end else if (scan_en) begin
      alloc_r[cnt_r]   <= upd.alloc;
      started_r[cnt_r] <= upd.started;
      if (upd.clr_marks) begin
        marks_r[cnt_r] <= '0;
      end else begin
        for (int k = 0; k < esm_pkg::MARK_W; k++) begin
          if (upd.set_marks[k]) marks_r[cnt_r][k] <= 1'b1;
        end
      end
    end
  end

endmodule
